// ===== hw/rtl/wps_pkg.sv =====
// Shared constants, codes and types of the waypoint sequencer.
// No dependencies; wps_atan and waypoint_sequencer import this package.
`default_nettype none
package wps_pkg;

    localparam int MAX_WAYPOINTS = 64;
    localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W         = $clog2(MAX_WAYPOINTS + 1);
    localparam int ENT_W         = 97;

    localparam int CORDIC_STEPS  = 20;
    localparam int STEP_W        = 5;
    localparam int ACC_W         = 45;
    localparam int ANG_W         = 24;

    localparam logic signed [ANG_W-1:0] PI20        = 24'sd3294199;
    localparam logic signed [15:0]      HEADING_MAX = 16'sd25736;
    localparam logic [15:0]             LEG_MIN_SQ  = 16'd4294;
    localparam logic [15:0]             ARRIVAL_RESET = 16'd9830;

    // action codes
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    typedef struct packed {
        logic start;
    } atan_ctrl_t;

    typedef struct packed {
        logic done;
    } atan_stat_t;

    // arctangent of 2^-i in units of 2^-20 rad
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic signed [ANG_W-1:0] a;
        case (i)
            5'd0:    a = 24'sd823550;
            5'd1:    a = 24'sd486170;
            5'd2:    a = 24'sd256879;
            5'd3:    a = 24'sd130396;
            5'd4:    a = 24'sd65451;
            5'd5:    a = 24'sd32757;
            5'd6:    a = 24'sd16383;
            5'd7:    a = 24'sd8192;
            5'd8:    a = 24'sd4096;
            5'd9:    a = 24'sd2048;
            5'd10:   a = 24'sd1024;
            5'd11:   a = 24'sd512;
            5'd12:   a = 24'sd256;
            5'd13:   a = 24'sd128;
            5'd14:   a = 24'sd64;
            5'd15:   a = 24'sd32;
            5'd16:   a = 24'sd16;
            5'd17:   a = 24'sd8;
            5'd18:   a = 24'sd4;
            5'd19:   a = 24'sd2;
            default: a = 24'sd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/wps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module wps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/wps_atan.sv =====
// Iterative atan2 unit: normalising shift, 20 CORDIC steps, Q3.13 rounding.
// Depends on wps_pkg.
`default_nettype none
module wps_atan (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wps_pkg::atan_ctrl_t ctrl,
    input  wire logic signed [32:0]  dx,
    input  wire logic signed [32:0]  dy,
    output wps_pkg::atan_stat_t      stat,
    output logic signed [15:0]       heading
);
    import wps_pkg::*;

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_NORM = 4'b0010,
        A_ROT  = 4'b0100,
        A_FIN  = 4'b1000
    } atan_state_t;

    atan_state_t              state_reg, state_next;
    logic signed [ACC_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [ANG_W-1:0]  z_reg, z_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     xneg_reg, xneg_next, yneg_reg, yneg_next;
    logic signed [15:0]       head_reg, head_next;

    logic [32:0]              ax, ay;
    logic signed [ACC_W-1:0]  xs, ys;
    logic signed [ANG_W-1:0]  zc, zq, zr;
    logic signed [ANG_W-1:0]  hr;
    logic signed [15:0]       hc;

    always_comb
    begin
        ax = dx[32] ? 33'(-dx) : 33'(dx);
        ay = dy[32] ? 33'(-dy) : 33'(dy);
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        zc = z_reg[ANG_W-1] ? '0 : z_reg;
        zq = xneg_reg ? PI20 - zc : zc;
        zr = zq + 24'sd64;
        hr = zr >>> 7;
        hc = (hr > ANG_W'(HEADING_MAX)) ? HEADING_MAX : 16'(hr);
    end

    // sequence the shift search, the rotations and the final rounding
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        step_next  = step_reg;
        xneg_next  = xneg_reg;
        yneg_next  = yneg_reg;
        head_next  = head_reg;
        stat.done  = 1'b0;
        case (state_reg)
            A_IDLE:
            begin
                if (ctrl.start)
                begin
                    x_next     = ACC_W'(ax);
                    y_next     = ACC_W'(ay);
                    z_next     = '0;
                    xneg_next  = dx[32];
                    yneg_next  = dy[32];
                    state_next = A_NORM;
                end
            end
            A_NORM:
            begin
                // shift left until the larger magnitude reaches 2^40
                if ((x_reg[ACC_W-1:40] | y_reg[ACC_W-1:40]) == '0)
                begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end
                else
                begin
                    step_next  = '0;
                    state_next = A_ROT;
                end
            end
            A_ROT:
            begin
                if (!y_reg[ACC_W-1])
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_entry(step_reg);
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_entry(step_reg);
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = A_FIN;
                end
            end
            A_FIN:
            begin
                head_next  = yneg_reg ? -hc : hc;
                stat.done  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        step_reg <= step_next;
        xneg_reg <= xneg_next;
        yneg_reg <= yneg_next;
        head_reg <= head_next;
    end

    assign heading = head_next;

endmodule
`default_nettype wire

// ===== hw/rtl/waypoint_sequencer.sv =====
// Top level of the waypoint sequencer: table, arrival test, leg heading.
// Depends on wps_pkg, wps_ram and wps_atan.
// Clear and append are done while idle; the first append also starts leg 0: the atan
// unit (normalising shift, 20 CORDIC steps, rounding) runs unless the entry keeps a
// fixed heading or the leg is too short. A tick runs the arrival test, in the radius
// box the squared-distance test (one shared 16x16 multiplier, four passes), and on
// arrival a new leg. One item at a time; in_ready is high only while no item is at
// work. Reset clears count, leg, landed flag and heading, sets the radius to 0.15 m.
`default_nettype none
module waypoint_sequencer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         action,
    input  wire logic signed [31:0] coord_x,
    input  wire logic signed [31:0] coord_y,
    input  wire logic signed [31:0] coord_z,
    input  wire logic               fixed_heading,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      target_x,
    output logic signed [31:0]      target_y,
    output logic signed [31:0]      target_z,
    output logic signed [15:0]      heading_target,
    output logic                    fly,
    output logic                    mission_done,
    output logic [5:0]              leg_index
);
    import wps_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_RD   = 11'b00000000010,
        S_ARR  = 11'b00000000100,
        S_SQ   = 11'b00000001000,
        S_DEC  = 11'b00000010000,
        S_LRD  = 11'b00000100000,
        S_LCAP = 11'b00001000000,
        S_LEG  = 11'b00010000000,
        S_WAIT = 11'b00100000000,
        S_RES  = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } seq_state_t;

    seq_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   cur_reg, cur_next;
    logic               landed_reg, landed_next;
    logic signed [15:0] head_reg, head_next;
    logic [15:0]        radius_reg;
    logic               tick_reg, tick_next;

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [31:0] ent_x_reg, ent_y_reg, ent_z_reg;
    logic               ent_keep_reg;
    logic signed [31:0] prv_x_reg, prv_y_reg;
    logic [15:0]        ex_reg, ey_reg, ez_reg;
    logic [1:0]         sq_reg;
    logic [33:0]        acc_reg;
    logic [31:0]        rsq_reg;

    logic               out_valid_reg;
    logic signed [31:0] tx_reg, ty_reg, tz_reg;
    logic signed [15:0] oh_reg;
    logic               fly_reg, done_reg;
    logic [5:0]         leg_reg;

    logic               in_beat, append_ok;
    logic [IDX_W-1:0]   cur_clamp, rd_addr;
    logic [ENT_W-1:0]   rd_data, wr_data;
    logic signed [31:0] rd_x, rd_y, rd_z;
    logic               rd_keep;
    logic [32:0]        mx, my, mz;
    logic signed [32:0] ldx, ldy;
    logic [32:0]        lax, lay;
    logic               degenerate;
    logic [15:0]        sq_op;
    logic [31:0]        sq_prod;
    logic [CNT_W-1:0]   next_leg;
    atan_ctrl_t         atan_ctrl;
    atan_stat_t         atan_stat;
    logic signed [15:0] atan_head;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_beat   = in_valid && in_ready;
    assign append_ok = in_beat && (action == ACT_APPEND) &&
                       (count_reg < CNT_W'(MAX_WAYPOINTS));
    assign wr_data   = {fixed_heading, coord_z, coord_y, coord_x};

    // clamp the leg into the table before the tick reads it
    always_comb
    begin
        cur_clamp = cur_reg;
        if ((CNT_W'(cur_reg) >= count_reg) && (count_reg != '0))
        begin
            cur_clamp = IDX_W'(count_reg - 1'b1);
        end
        rd_addr = (state_reg == S_RD) ? cur_clamp : cur_reg;
    end

    wps_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WAYPOINTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (append_ok),
        .wr_addr (IDX_W'(count_reg)),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // split the stored entry and take error magnitudes against the position
    always_comb
    begin
        rd_x    = rd_data[31:0];
        rd_y    = rd_data[63:32];
        rd_z    = rd_data[95:64];
        rd_keep = rd_data[96];
        mx = 33'({rd_x[31], rd_x} - {px_reg[31], px_reg});
        my = 33'({rd_y[31], rd_y} - {py_reg[31], py_reg});
        mz = 33'({rd_z[31], rd_z} - {pz_reg[31], pz_reg});
        mx = mx[32] ? 33'(-mx) : mx;
        my = my[32] ? 33'(-my) : my;
        mz = mz[32] ? 33'(-mz) : mz;
    end

    // leg vector and the short-leg test
    always_comb
    begin
        ldx = {ent_x_reg[31], ent_x_reg} - {prv_x_reg[31], prv_x_reg};
        ldy = {ent_y_reg[31], ent_y_reg} - {prv_y_reg[31], prv_y_reg};
        lax = ldx[32] ? 33'(-ldx) : 33'(ldx);
        lay = ldy[32] ? 33'(-ldy) : 33'(ldy);
        degenerate = (lax < 33'd66) && (lay < 33'd66) &&
                     ((16'(lax[6:0] * lax[6:0]) + 16'(lay[6:0] * lay[6:0])) <= LEG_MIN_SQ);
    end

    // shared squaring multiplier
    always_comb
    begin
        case (sq_reg)
            2'd0:    sq_op = ex_reg;
            2'd1:    sq_op = ey_reg;
            2'd2:    sq_op = ez_reg;
            default: sq_op = radius_reg;
        endcase
        sq_prod = sq_op * sq_op;
    end

    assign next_leg = CNT_W'(cur_reg) + 1'b1;

    wps_atan u_atan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (atan_ctrl),
        .dx      (ldx),
        .dy      (ldy),
        .stat    (atan_stat),
        .heading (atan_head)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        landed_next     = landed_reg;
        head_next       = head_reg;
        tick_next       = tick_reg;
        atan_ctrl.start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    case (action)
                        ACT_CLEAR:
                        begin
                            count_next  = '0;
                            cur_next    = '0;
                            landed_next = 1'b0;
                            head_next   = '0;
                        end
                        ACT_APPEND:
                        begin
                            if (append_ok)
                            begin
                                count_next = count_reg + 1'b1;
                                if (count_reg == '0)
                                begin
                                    tick_next  = 1'b0;
                                    state_next = S_LEG;
                                end
                            end
                        end
                        ACT_TICK:
                        begin
                            tick_next  = 1'b1;
                            state_next = S_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                cur_next   = cur_clamp;
                state_next = S_ARR;
            end
            S_ARR:
            begin
                if (count_reg == '0 || landed_reg)
                begin
                    state_next = S_RES;
                end
                else if (mx < 33'(radius_reg) && my < 33'(radius_reg) &&
                         mz < 33'(radius_reg))
                begin
                    state_next = S_SQ;
                end
                else
                begin
                    state_next = S_RES;
                end
            end
            S_SQ:
            begin
                if (sq_reg == 2'd3)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (34'(acc_reg) < 34'(rsq_reg))
                begin
                    if (ent_z_reg == '0)
                    begin
                        landed_next = 1'b1;
                        state_next  = S_RES;
                    end
                    else if (next_leg < count_reg)
                    begin
                        cur_next   = IDX_W'(next_leg);
                        state_next = S_LRD;
                    end
                    else
                    begin
                        state_next = S_RES;
                    end
                end
                else
                begin
                    state_next = S_RES;
                end
            end
            S_LRD:
            begin
                state_next = S_LCAP;
            end
            S_LCAP:
            begin
                state_next = S_LEG;
            end
            S_LEG:
            begin
                if (ent_keep_reg)
                begin
                    head_next  = '0;
                    state_next = tick_reg ? S_RES : S_IDLE;
                end
                else if (degenerate)
                begin
                    state_next = tick_reg ? S_RES : S_IDLE;
                end
                else
                begin
                    atan_ctrl.start = 1'b1;
                    state_next      = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (atan_stat.done)
                begin
                    head_next  = atan_head;
                    state_next = tick_reg ? S_RES : S_IDLE;
                end
            end
            S_RES:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cur_reg       <= '0;
            landed_reg    <= 1'b0;
            head_reg      <= '0;
            radius_reg    <= ARRIVAL_RESET;
            tick_reg      <= 1'b0;
            sq_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cur_reg    <= cur_next;
            landed_reg <= landed_next;
            head_reg   <= head_next;
            tick_reg   <= tick_next;
            if (cfg_valid && cfg_ready)
            begin
                radius_reg <= cfg_data;
            end
            sq_reg <= (state_reg == S_SQ) ? sq_reg + 1'b1 : 2'd0;
            if (state_reg == S_RES)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
            pz_reg <= coord_z;
            if (count_reg == '0)
            begin
                ent_x_reg    <= coord_x;
                ent_y_reg    <= coord_y;
                ent_z_reg    <= coord_z;
                ent_keep_reg <= fixed_heading;
                prv_x_reg    <= '0;
                prv_y_reg    <= '0;
            end
        end
        if (state_reg == S_ARR || state_reg == S_LCAP)
        begin
            ent_x_reg    <= rd_x;
            ent_y_reg    <= rd_y;
            ent_z_reg    <= rd_z;
            ent_keep_reg <= rd_keep;
        end
        if (state_reg == S_ARR)
        begin
            ex_reg  <= mx[15:0];
            ey_reg  <= my[15:0];
            ez_reg  <= mz[15:0];
            acc_reg <= '0;
        end
        if (state_reg == S_SQ)
        begin
            if (sq_reg == 2'd3)
            begin
                rsq_reg <= sq_prod;
            end
            else
            begin
                acc_reg <= acc_reg + 34'(sq_prod);
            end
        end
        if (state_reg == S_DEC)
        begin
            prv_x_reg <= ent_x_reg;
            prv_y_reg <= ent_y_reg;
        end
        if (state_reg == S_RES)
        begin
            tx_reg   <= (count_reg == '0) ? '0 : ent_x_reg;
            ty_reg   <= (count_reg == '0) ? '0 : ent_y_reg;
            tz_reg   <= (count_reg == '0) ? '0 : ent_z_reg;
            oh_reg   <= head_reg;
            fly_reg  <= !landed_reg && (count_reg != '0);
            done_reg <= landed_reg;
            leg_reg  <= 6'(cur_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign target_x       = tx_reg;
    assign target_y       = ty_reg;
    assign target_z       = tz_reg;
    assign heading_target = oh_reg;
    assign fly            = fly_reg;
    assign mission_done   = done_reg;
    assign leg_index      = leg_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/wps_checker.sv =====
// Port-level checker for the waypoint sequencer, bound to the top level.
// Depends on waypoint_sequencer's ports only.
`default_nettype none
module wps_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [31:0] target_x,
    input wire logic signed [31:0] target_y,
    input wire logic signed [31:0] target_z,
    input wire logic               fly,
    input wire logic               mission_done
);

    // hold a stalled result beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(target_x) && $stable(fly))
        else $error("stalled result changed");

    // take no item while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while result pending");

    // never flag fly and landed in the same result
    a_land: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(fly && mission_done))
        else $error("fly and landed together");

    // an empty table shows a zero target
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fly && !mission_done |->
            target_x == 0 && target_y == 0 && target_z == 0)
        else $error("empty table with non-zero target");

endmodule

bind waypoint_sequencer wps_checker u_wps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .target_x     (target_x),
    .target_y     (target_y),
    .target_z     (target_z),
    .fly          (fly),
    .mission_done (mission_done)
);
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for waypoint_sequencer: a heading/target predictor in a small
// scoreboard class, handshake drivers and a stalling result sink.
// Depends on wps_pkg and the waypoint_sequencer RTL only.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wps_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int TABLE_DEPTH = 64;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
        logic signed [15:0] heading;
        logic               fly;
        logic               done;
        logic [5:0]         leg;
    } nav_result_t;

    // Predicts navigation results and holds the ones still owed by the block
    class nav_board;
        longint wx[TABLE_DEPTH];
        longint wy[TABLE_DEPTH];
        longint wz[TABLE_DEPTH];
        bit     wkeep[TABLE_DEPTH];
        int     count;
        int     leg;
        bit     landed;
        int     heading;
        longint radius;
        nav_result_t owed[$];
        int     mismatches;
        int     checked;
        int     accepted;
        int     landings;
        int     advances;
        longint cordic_angle[20];

        function new();
            cordic_angle = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                             4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
            count = 0; leg = 0; landed = 0; heading = 0;
            radius = ARRIVAL_RESET;
            mismatches = 0; checked = 0; accepted = 0; landings = 0; advances = 0;
        endfunction

        function longint absval(longint v);
            return v < 0 ? -v : v;
        endfunction

        // CORDIC vectoring bearing in Q3.13
        function int bearing(longint dx, longint dy);
            longint unsigned ax, ay, m;
            longint x, y, z, xs, ys, h;
            int s;
            ax = absval(dx); ay = absval(dy);
            m = ax > ay ? ax : ay;
            s = 0;
            while (s < 63 && (m << s) < (64'd1 << 40)) s++;
            x = ax << s; y = ay << s; z = 0;
            for (int i = 0; i < 20; i++) begin
                xs = x >>> i; ys = y >>> i;
                if (y >= 0) begin x = x + ys; y = y - xs; z += cordic_angle[i]; end
                else begin x = x - ys; y = y + xs; z -= cordic_angle[i]; end
            end
            if (z < 0) z = 0;
            if (dx < 0) z = longint'(PI20) - z;
            h = (z + 64) >>> 7;
            if (h > HEADING_MAX) h = HEADING_MAX;
            if (dy < 0) h = -h;
            return int'(h);
        endfunction

        function void begin_leg(int k);
            longint fx, fy, dx, dy;
            if (k >= count) return;
            if (wkeep[k]) begin heading = 0; return; end
            fx = 0; fy = 0;
            if (k > 0) begin fx = wx[k-1]; fy = wy[k-1]; end
            dx = wx[k] - fx; dy = wy[k] - fy;
            // drop degenerate legs, hold the old heading
            if (absval(dx) < 66 && absval(dy) < 66 &&
                dx*dx + dy*dy <= longint'(LEG_MIN_SQ)) return;
            heading = bearing(dx, dy);
        endfunction

        function bit reached(int k, longint px, longint py, longint pz);
            longint ex, ey, ez;
            ex = absval(wx[k] - px); ey = absval(wy[k] - py); ez = absval(wz[k] - pz);
            if (ex >= radius || ey >= radius || ez >= radius) return 0;
            return ex*ex + ey*ey + ez*ez < radius*radius;
        endfunction

        // Note an accepted input beat and queue whatever result it owes
        function void note_item(logic [1:0] act, longint cx, longint cy, longint cz, bit keep);
            nav_result_t r;
            accepted++;
            if (act == ACT_CLEAR) begin
                count = 0; leg = 0; landed = 0; heading = 0;
                return;
            end
            if (act == ACT_APPEND) begin
                if (count < TABLE_DEPTH) begin
                    wx[count] = cx; wy[count] = cy; wz[count] = cz; wkeep[count] = keep;
                    count++;
                    if (count == 1) begin_leg(0);
                end
                return;
            end
            if (act != ACT_TICK) return;
            if (leg >= count && count > 0) leg = count - 1;
            if (!landed && count > 0 && reached(leg, cx, cy, cz)) begin
                if (wz[leg] == 0) begin landed = 1; landings++; end
                else if (leg + 1 < count) begin
                    leg++; advances++;
                    begin_leg(leg);
                end
            end
            r.tx = count > 0 ? wx[leg][31:0] : '0;
            r.ty = count > 0 ? wy[leg][31:0] : '0;
            r.tz = count > 0 ? wz[leg][31:0] : '0;
            r.heading = heading[15:0];
            r.fly = !landed && count > 0;
            r.done = landed;
            r.leg = leg[5:0];
            owed = {owed, r};
        endfunction

        function void check_result(nav_result_t got);
            nav_result_t want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
                return;
            end
            want = owed.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d mismatch: expected %p, got %p", checked, want, got);
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic cfg_valid, cfg_ready;
    logic [15:0] cfg_data;
    logic in_valid, in_ready;
    logic [1:0] action;
    logic signed [31:0] coord_x, coord_y, coord_z;
    logic fixed_heading;
    logic out_valid, out_ready;
    logic signed [31:0] target_x, target_y, target_z;
    logic signed [15:0] heading_target;
    logic fly, mission_done;
    logic [5:0] leg_index;

    nav_board board = new();
    int send_gap_pct, sink_stall_pct;
    int hold_ask = 0;
    int hold_seen = 0;
    int hold_left = 0;
    longint cycles = 0;

    waypoint_sequencer dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .action(action),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .fixed_heading(fixed_heading),
        .out_valid(out_valid), .out_ready(out_ready),
        .target_x(target_x), .target_y(target_y), .target_z(target_z),
        .heading_target(heading_target), .fly(fly), .mission_done(mission_done),
        .leg_index(leg_index)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb failed");
            $finish;
        end
    end

    // Result sink: random stalls plus a long hold-off whenever one is asked for
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end
        else if (hold_seen != hold_ask)
        begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Check every result beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result({target_x, target_y, target_z, heading_target,
                                fly, mission_done, leg_index});
    end

    // Drive one input beat and hold it until accepted
    task automatic send(logic [1:0] act, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                        bit keep);
        int gap;
        in_valid <= 1'b1;
        action <= act; coord_x <= x; coord_y <= y; coord_z <= z; fixed_heading <= keep;
        do @(posedge clk); while (!in_ready);
        board.note_item(act, longint'($signed(x)), longint'($signed(y)),
                        longint'($signed(z)), keep);
        if ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.owed.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the arrival radius once the block is idle
    task automatic set_radius(logic [15:0] r);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= r;
        do @(posedge clk); while (!cfg_ready);
        board.radius = r;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            2: return $urandom_range(0, 32'h0000_0FFF) - 32'h0000_0800;
            default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    // Position near the current target, inside or just outside the radius
    task automatic tick_near();
        longint tx, ty, tz, span;
        int k;
        if (board.count == 0)
        begin
            send(ACT_TICK, rand_coord(), rand_coord(), rand_coord(), 0);
            return;
        end
        k = board.leg < board.count ? board.leg : board.count - 1;
        tx = board.wx[k]; ty = board.wy[k]; tz = board.wz[k];
        span = board.radius / 2;
        if ($urandom_range(3) == 0) span = board.radius + 4;
        if (span > 0)
        begin
            tx += longint'($urandom_range(32'(2*span))) - span;
            ty += longint'($urandom_range(32'(2*span))) - span;
            tz += longint'($urandom_range(32'(2*span))) - span;
        end
        send(ACT_TICK, tx[31:0], ty[31:0], tz[31:0], 0);
    endtask

    // One mission: clear, a short waypoint list, ticks that follow it
    task automatic mission();
        int n;
        logic [31:0] x, y, z;
        send(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom_range(1));
        n = $urandom_range(1, 8);
        x = rand_coord(); y = rand_coord();
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(5))
                0: ;                                         // repeat the last xy
                1: begin x += $urandom_range(60) - 30; y += $urandom_range(60) - 30; end
                default: begin x = rand_coord(); y = rand_coord(); end
            endcase
            z = ($urandom_range(3) == 0) ? 32'd0 : rand_coord();
            send(ACT_APPEND, x, y, z, $urandom_range(4) == 0);
        end
        repeat ($urandom_range(2, 3 * n + 2))
        begin
            if ($urandom_range(9) == 0)
                send($urandom_range(9) == 0 ? ACT_UNUSED : ACT_TICK,
                     $urandom, $urandom, $urandom, $urandom_range(1));
            else
                tick_near();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0; cfg_data = '0;
        in_valid = 1'b0; action = ACT_CLEAR;
        coord_x = '0; coord_y = '0; coord_z = '0; fixed_heading = 1'b0;
        send_gap_pct = 12; sink_stall_pct = 61;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes, unused code, keep-heading, landing
        send(ACT_TICK, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1);
        send(ACT_UNUSED, 32'h1234_5678, 32'h0, 32'h0, 1);
        send(ACT_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 1);
        send(ACT_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_0000, 0);
        send(ACT_APPEND, 32'h7FFF_FFFF, 32'h8000_0010, 32'h0, 0);
        send(ACT_APPEND, 32'hFFFF_0000, 32'h0001_0000, 32'h0, 0);
        send(ACT_TICK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 0);
        send(ACT_TICK, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_0000, 0);
        send(ACT_TICK, 32'h7FFF_FFFF, 32'h8000_0010, 32'h0, 0);
        send(ACT_TICK, 32'h0, 32'h0, 32'h0, 0);
        send(ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        send(ACT_APPEND, 32'hFFFF_0000, 32'h0, 32'h0, 0);
        send(ACT_APPEND, 32'hFFFF_0000, 32'h0, 32'h0001_0000, 0);
        send(ACT_TICK, 32'hFFFF_0000, 32'h0, 32'h0, 0);
        send(ACT_TICK, 32'hFFFF_0000, 32'h0, 32'h0, 0);
        send(ACT_CLEAR, 0, 0, 0, 0);
        // Fill the table past full; the last appends are dropped
        for (int i = 0; i < TABLE_DEPTH + 2; i++)
            send(ACT_APPEND, i << 16, -(i << 15), 32'h0001_0000 + i, i[0]);
        send(ACT_TICK, 0, 0, 32'h0001_0000, 0);

        // Radius extremes, then random missions under three idling regimes
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_radius(16'd0);
                1: set_radius(16'hFFFF);
                2: set_radius(ARRIVAL_RESET);
                default: set_radius(16'($urandom_range(16'h0040, 16'hFFFF)));
            endcase
            if (phase == 2) begin send_gap_pct = 61; sink_stall_pct = 12; end
            if (phase == 4) begin send_gap_pct = 0; sink_stall_pct = 0; end
            if (phase == 3)
            begin
                // back up the sink while the sender keeps offering
                hold_ask <= hold_ask + 1;
                repeat (6) tick_near();
            end
            while (board.accepted < 100 + (phase + 1) * 170)
                mission();
        end

        drain();
        $display("%0d input beats taken, %0d navigation results compared",
                 board.accepted, board.checked);
        $display("missions covered %0d leg advances and %0d landings",
                 board.advances, board.landings);
        if (board.mismatches == 0 && board.owed.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
`default_nettype wire
